// ===== rtl/pspo_pkg.sv =====
// ----------------------------------------------------------------------------
// pspo_pkg
// Shared types and constants of the polar sort simple polygon order block.
// ----------------------------------------------------------------------------
package pspo_pkg;

    // Width of the arrival index carried on the result channel.
    localparam int POINT_IDX_W = 6;

    // Result tdata is padded to a whole byte.
    localparam int OUT_DATA_W = 8;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RANK = 4'b0010,
        ST_TAIL = 4'b0100,
        ST_EMIT = 4'b1000
    } back_state_t;

endpackage

// ===== rtl/pspo_front.sv =====
// ----------------------------------------------------------------------------
// pspo_front
// Accepts points, writes them into the current bank and tracks the anchor.
// ----------------------------------------------------------------------------
module pspo_front #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16,
    parameter int IW         = 6,
    parameter int CW         = 7,
    parameter int JOB_W      = 1 + 7 + 6 + 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic signed [COORD_BITS-1:0] s_x,
    input  logic signed [COORD_BITS-1:0] s_y,
    input  logic                         s_last,
    output logic                         wr_en,
    output logic [IW:0]                  wr_addr,
    output logic [2*COORD_BITS-1:0]      wr_data,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic [JOB_W-1:0]             push_data
);
    import pspo_pkg::*;

    typedef struct packed {
        logic                         bank;
        logic [CW-1:0]                n;
        logic [IW-1:0]                aidx;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] ax;
    } job_t;

    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         bank_reg, bank_next;
    logic [IW-1:0]                best_idx_reg, best_idx_next;
    logic signed [COORD_BITS-1:0] best_x_reg, best_x_next;
    logic signed [COORD_BITS-1:0] best_y_reg, best_y_next;
    logic                         accept, room, take_new;
    job_t                         job;

    assign s_tready = push_ready;
    assign accept   = s_tvalid & push_ready;
    assign room     = cnt_reg < CW'(MAX_POINTS);

    // The first point of a set is always the anchor so far; later points replace it
    // only when strictly lower, so an equal point keeps the earlier index.
    assign take_new = room && ((cnt_reg == '0) || (s_x < best_x_reg) ||
                               ((s_x == best_x_reg) && (s_y < best_y_reg)));

    assign best_idx_next = take_new ? cnt_reg[IW-1:0] : best_idx_reg;
    assign best_x_next   = take_new ? s_x : best_x_reg;
    assign best_y_next   = take_new ? s_y : best_y_reg;

    assign wr_en   = accept & room;
    assign wr_addr = {bank_reg, cnt_reg[IW-1:0]};
    assign wr_data = {s_y, s_x};

    always_comb begin
        job.bank = bank_reg;
        job.n    = room ? cnt_reg + CW'(1) : cnt_reg;
        job.aidx = best_idx_next;
        job.ax   = best_x_next;
        job.ay   = best_y_next;
    end

    assign push_valid = accept & s_last;
    assign push_data  = job;

    always_comb begin
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        if (accept) begin
            if (s_last) begin
                cnt_next  = '0;
                bank_next = ~bank_reg;
            end else if (room) begin
                cnt_next = cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            best_idx_reg <= best_idx_next;
            best_x_reg   <= best_x_next;
            best_y_reg   <= best_y_next;
        end
    end

endmodule

// ===== rtl/pspo_job_queue.sv =====
// ----------------------------------------------------------------------------
// pspo_job_queue
// Two-entry queue of closed point sets between the loader and the sorter.
// ----------------------------------------------------------------------------
module pspo_job_queue #(
    parameter int W = 46
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    output logic         push_ready,
    input  logic [W-1:0] push_data,
    output logic         pop_valid,
    input  logic         pop,
    output logic [W-1:0] pop_data
);
    import pspo_pkg::*;

    logic [W-1:0] slot_reg [0:1];
    logic         wp_reg, rp_reg;
    logic [1:0]   count_reg, count_next;
    logic         do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = slot_reg[rp_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= 1'b0;
            rp_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wp_reg <= ~wp_reg;
            end
            if (do_pop) begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wp_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/pspo_back.sv =====
// ----------------------------------------------------------------------------
// pspo_back
// Ranks each point against all others, finds the collinear tail and emits the
// polygon order from the order memory.
// ----------------------------------------------------------------------------
module pspo_back #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16,
    parameter int IW         = 6,
    parameter int CW         = 7,
    parameter int JOB_W      = 1 + 7 + 6 + 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                wr_en,
    input  logic [IW:0]                         wr_addr,
    input  logic [2*COORD_BITS-1:0]             wr_data,
    input  logic                                job_valid,
    input  logic [JOB_W-1:0]                    job_data,
    output logic                                job_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pspo_pkg::POINT_IDX_W-1:0]    m_index,
    output logic                                m_last
);
    import pspo_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int DW = CB + 1;
    localparam int PW = 2 * DW;
    localparam int MW = DW + 1;
    localparam int AW = IW + 1;

    typedef struct packed {
        logic                 bank;
        logic [CW-1:0]        n;
        logic [IW-1:0]        aidx;
        logic signed [CB-1:0] ay;
        logic signed [CB-1:0] ax;
    } job_t;

    job_t        job;
    back_state_t state_reg, state_next;
    logic [CW-1:0] nm1;

    assign job = job_t'(job_data);
    assign nm1 = job.n - CW'(1);

    // Point memory, two banks, two read ports.
    logic [2*CB-1:0] point_mem [0:2**AW-1];
    logic [AW-1:0]   ra_addr, rb_addr;
    logic [2*CB-1:0] pa_reg, pb_reg;

    // Order memory: slot of each sorted position.
    logic [IW-1:0] order_mem [0:2**IW-1];
    logic          ow_en;
    logic [IW-1:0] ow_addr, ow_data, or_addr, oq_reg;

    // Rank issue and tags.
    logic          iss_on_reg;
    logic [IW-1:0] i_reg, j_reg;
    logic          r1_vld_reg, r1_first_reg, r1_last_reg;
    logic [IW-1:0] r1_i_reg, r1_j_reg;
    logic          r2_vld_reg, r2_first_reg, r2_last_reg;
    logic [IW-1:0] r2_i_reg, r2_j_reg;
    logic [IW-1:0] cnt_reg, total, rank;
    logic          j_first, inc, row_last;

    // Tail scan.
    logic          k_on_reg;
    logic [IW-1:0] k_reg;
    logic          t1_vld_reg, t2_vld_reg, t3_vld_reg;
    logic          t1_last_reg, t2_last_reg, t3_last_reg;
    logic [IW-1:0] t1_k_reg, t2_k_reg, t3_k_reg;
    logic [IW-1:0] tail_reg;

    // Emission.
    logic          e_on_reg, pend_reg, pend_last_reg, e_issue, e_last;
    logic [IW-1:0] e_reg, e_addr;
    logic [CW:0]   e_mirror;
    logic          m_tvalid_reg, m_last_reg;
    logic [POINT_IDX_W-1:0] m_index_reg;

    // Arithmetic.
    logic signed [DW-1:0] ax, ay, bx, by, abs_ay, abs_by;
    logic signed [DW-1:0] bx2_reg, by2_reg, fx_reg, fy_reg;
    logic signed [DW-1:0] lm1, lm2, rm1, rm2;
    logic signed [PW-1:0] l_next, r_next, l_reg, r_reg;
    logic [MW-1:0]        ma_reg, mb_reg;
    logic                 in_rank;

    assign in_rank = (state_reg == ST_RANK);

    assign ra_addr = (state_reg == ST_TAIL) ? {job.bank, oq_reg} : {job.bank, j_reg};
    assign rb_addr = {job.bank, i_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            point_mem[wr_addr] <= wr_data;
        end
        pa_reg <= point_mem[ra_addr];
        pb_reg <= point_mem[rb_addr];
    end

    always_ff @(posedge aclk) begin
        if (ow_en) begin
            order_mem[ow_addr] <= ow_data;
        end
        oq_reg <= order_mem[or_addr];
    end

    // Offsets from the anchor. The anchor has the least x, so dx is never negative
    // and every other point lies within a half turn of it.
    assign ax = $signed({pa_reg[CB-1], pa_reg[CB-1:0]}) - $signed({job.ax[CB-1], job.ax});
    assign ay = $signed({pa_reg[2*CB-1], pa_reg[2*CB-1:CB]}) - $signed({job.ay[CB-1], job.ay});
    assign bx = $signed({pb_reg[CB-1], pb_reg[CB-1:0]}) - $signed({job.ax[CB-1], job.ax});
    assign by = $signed({pb_reg[2*CB-1], pb_reg[2*CB-1:CB]}) - $signed({job.ay[CB-1], job.ay});
    assign abs_ay = ay[DW-1] ? -ay : ay;
    assign abs_by = by[DW-1] ? -by : by;

    // Ranking compares a against b; the tail scan compares the final point against a.
    assign lm1 = in_rank ? ax : fx_reg;
    assign lm2 = in_rank ? by : ay;
    assign rm1 = in_rank ? ay : fy_reg;
    assign rm2 = in_rank ? bx : ax;
    assign l_next = lm1 * lm2;
    assign r_next = rm1 * rm2;

    always_ff @(posedge aclk) begin
        l_reg   <= l_next;
        r_reg   <= r_next;
        // On one ray the taxicab length orders points exactly as the true length.
        ma_reg  <= {1'b0, ax} + {1'b0, abs_ay};
        mb_reg  <= {1'b0, bx} + {1'b0, abs_by};
        bx2_reg <= bx;
        by2_reg <= by;
    end

    assign j_first = (l_reg > r_reg) ||
                     ((l_reg == r_reg) && ((ma_reg < mb_reg) ||
                                           ((ma_reg == mb_reg) && (r2_j_reg < r2_i_reg))));
    assign inc   = j_first && (r2_j_reg != r2_i_reg) && (r2_j_reg != job.aidx);
    assign total = (r2_first_reg ? '0 : cnt_reg) + IW'(inc);
    assign rank  = (r2_i_reg == job.aidx) ? '0 : total + IW'(1);

    assign row_last = in_rank && r2_vld_reg && r2_last_reg;
    assign ow_en    = row_last;
    assign ow_addr  = rank;
    assign ow_data  = r2_i_reg;

    // Emission reads the head up to the tail, then the rest mirrored.
    assign e_mirror = {1'b0, job.n} + (CW+1)'(tail_reg) - (CW+1)'(e_reg);
    assign e_addr   = (e_reg <= tail_reg) ? e_reg : e_mirror[IW-1:0];
    assign e_last   = (CW'(e_reg) == nm1);
    assign e_issue  = (state_reg == ST_EMIT) && e_on_reg && !pend_reg && !m_tvalid_reg;
    assign or_addr  = (state_reg == ST_TAIL) ? k_reg : e_addr;

    assign job_pop  = (state_reg == ST_EMIT) && pend_reg && pend_last_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    state_next = ST_RANK;
                end
            end
            ST_RANK: begin
                if (row_last && (CW'(r2_i_reg) == nm1)) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (t3_vld_reg && t3_last_reg) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (job_pop) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            iss_on_reg   <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            r1_vld_reg   <= 1'b0;
            r2_vld_reg   <= 1'b0;
            k_on_reg     <= 1'b0;
            k_reg        <= '0;
            t1_vld_reg   <= 1'b0;
            t2_vld_reg   <= 1'b0;
            t3_vld_reg   <= 1'b0;
            tail_reg     <= '0;
            e_on_reg     <= 1'b0;
            e_reg        <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Ranking: one pair per cycle, row i against every j.
            r1_vld_reg <= in_rank && iss_on_reg;
            r2_vld_reg <= r1_vld_reg;
            if (state_reg == ST_IDLE && job_valid) begin
                iss_on_reg <= 1'b1;
                i_reg      <= '0;
                j_reg      <= '0;
            end else if (in_rank && iss_on_reg) begin
                if (CW'(j_reg) == nm1) begin
                    j_reg <= '0;
                    i_reg <= i_reg + IW'(1);
                    if (CW'(i_reg) == nm1) begin
                        iss_on_reg <= 1'b0;
                    end
                end else begin
                    j_reg <= j_reg + IW'(1);
                end
            end

            // Tail scan over sorted positions.
            t1_vld_reg <= (state_reg == ST_TAIL) && k_on_reg;
            t2_vld_reg <= t1_vld_reg;
            t3_vld_reg <= t2_vld_reg;
            if (row_last && (CW'(r2_i_reg) == nm1)) begin
                k_on_reg <= 1'b1;
                k_reg    <= '0;
                tail_reg <= '0;
            end else if ((state_reg == ST_TAIL) && k_on_reg) begin
                if (CW'(k_reg) == nm1) begin
                    k_on_reg <= 1'b0;
                end else begin
                    k_reg <= k_reg + IW'(1);
                end
            end
            if ((state_reg == ST_TAIL) && t3_vld_reg && (l_reg != r_reg)) begin
                tail_reg <= t3_k_reg;
            end

            // Emission.
            if ((state_reg == ST_TAIL) && t3_vld_reg && t3_last_reg) begin
                e_on_reg <= 1'b1;
                e_reg    <= '0;
            end else if (e_issue) begin
                e_reg <= e_reg + IW'(1);
                if (e_last) begin
                    e_on_reg <= 1'b0;
                end
            end
            if (e_issue) begin
                pend_reg <= 1'b1;
            end else if (pend_reg) begin
                pend_reg <= 1'b0;
            end
            if (pend_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        r1_i_reg     <= i_reg;
        r1_j_reg     <= j_reg;
        r1_first_reg <= (j_reg == '0);
        r1_last_reg  <= (CW'(j_reg) == nm1);
        r2_i_reg     <= r1_i_reg;
        r2_j_reg     <= r1_j_reg;
        r2_first_reg <= r1_first_reg;
        r2_last_reg  <= r1_last_reg;
        if (in_rank && r2_vld_reg) begin
            cnt_reg <= total;
        end
        // Keep the offset of whichever point lands in the final position.
        if (row_last && (CW'(rank) == nm1)) begin
            fx_reg <= bx2_reg;
            fy_reg <= by2_reg;
        end
        t1_k_reg    <= k_reg;
        t1_last_reg <= (CW'(k_reg) == nm1);
        t2_k_reg    <= t1_k_reg;
        t2_last_reg <= t1_last_reg;
        t3_k_reg    <= t2_k_reg;
        t3_last_reg <= t2_last_reg;
        if (e_issue) begin
            pend_last_reg <= e_last;
        end
        if (pend_reg) begin
            m_index_reg <= POINT_IDX_W'(oq_reg);
            m_last_reg  <= pend_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_index  = m_index_reg;
    assign m_last   = m_last_reg;

endmodule

// ===== rtl/polar_sort_simple_polygon_order_core.sv =====
// ----------------------------------------------------------------------------
// polar_sort_simple_polygon_order_core
// Orders a set of points into a simple polygon by angle about the anchor.
// ----------------------------------------------------------------------------
// Points enter on the s_ channel, one word each, tlast on the final point of a
// set. Up to MAX_POINTS points are kept; further points are dropped, though their
// tlast still closes the set. The anchor is the lowest-x, then lowest-y point.
// On the m_ channel the block returns one word per stored point: its arrival
// index in polygon order, with tlast on the final one.
// Points are written into the current bank as they are accepted. After the closing
// word the sorter compares every point with every other one, one pair per cycle
// through a two-multiplier pipeline. A new result is read from the order memory
// only once the previous word has left the output register.
// Two point banks let the next set load while the current one is sorted; the
// input stalls only when both banks hold closed sets.
// A stalled receiver holds the output register and, in turn, the sorter.
// Reset empties the queue and returns both sides to idle; memory contents are
// not cleared and need not be.
// ----------------------------------------------------------------------------
module polar_sort_simple_polygon_order_core #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // x_coord, y_coord
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]         s_tdata,
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // point_index, zero fill
    output logic [pspo_pkg::OUT_DATA_W-1:0]           m_tdata,
    output logic                                      m_tlast
);
    import pspo_pkg::*;

    localparam int IW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int JOB_W = 1 + CW + IW + 2 * COORD_BITS;

    logic                    wr_en;
    logic [IW:0]             wr_addr;
    logic [2*COORD_BITS-1:0] wr_data;
    logic                    push_valid, push_ready, job_valid, job_pop;
    logic [JOB_W-1:0]        push_data, job_data;
    logic [POINT_IDX_W-1:0]  m_index;

    pspo_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .IW         (IW),
        .CW         (CW),
        .JOB_W      (JOB_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_x        ($signed(s_tdata[COORD_BITS-1:0])),
        .s_y        ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
        .s_last     (s_tlast),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    pspo_job_queue #(
        .W (JOB_W)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (job_valid),
        .pop        (job_pop),
        .pop_data   (job_data)
    );

    pspo_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .IW         (IW),
        .CW         (CW),
        .JOB_W      (JOB_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_valid (job_valid),
        .job_data  (job_data),
        .job_pop   (job_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_index   (m_index),
        .m_last    (m_tlast)
    );

    assign m_tdata = {{(OUT_DATA_W-POINT_IDX_W){1'b0}}, m_index};

endmodule

// ===== tb/polygon_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_order_checker
// Watches both channels of the polygon order block, predicts the arrival-index
// order of every closed point set and compares each result word with it.
// ----------------------------------------------------------------------------
module polygon_order_checker #(
    parameter int MAX_POINTS = 64,
    parameter int COORD_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                  s_tlast,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [pspo_pkg::OUT_DATA_W-1:0]       m_tdata,
    input  logic                                  m_tlast,
    output int                                    fail_count,
    output int                                    pending_count
);

    typedef struct {
        logic [5:0] idx;
        logic       last;
    } order_word_t;

    longint set_x[MAX_POINTS];
    longint set_y[MAX_POINTS];
    int     set_size;
    order_word_t order_queue[$];

    assign pending_count = order_queue.size();

    // Sign of the cross product of (a - anchor) and (b - anchor).
    function automatic int cross_sign(int o, int a, int b);
        longint l, r;
        l = (set_x[a] - set_x[o]) * (set_y[b] - set_y[o]);
        r = (set_y[a] - set_y[o]) * (set_x[b] - set_x[o]);
        return (l > r) ? 1 : ((l < r) ? -1 : 0);
    endfunction

    function automatic longint dist_sq(int o, int a);
        longint dx, dy;
        dx = set_x[a] - set_x[o];
        dy = set_y[a] - set_y[o];
        return dx * dx + dy * dy;
    endfunction

    function automatic bit goes_first(int o, int a, int b);
        int t;
        t = cross_sign(o, a, b);
        if (t != 0) return t > 0;
        if (dist_sq(o, a) != dist_sq(o, b)) return dist_sq(o, a) < dist_sq(o, b);
        return a < b;
    endfunction

    task automatic queue_polygon_order(int n);
        int ord[MAX_POINTS];
        int anchor, i, j, k, tail, tmp;
        order_word_t w;
        anchor = 0;
        tail = 0;
        for (i = 0; i < n; i++) ord[i] = i;
        for (i = 1; i < n; i++)
            if (set_x[i] < set_x[anchor] ||
                (set_x[i] == set_x[anchor] && set_y[i] < set_y[anchor]))
                anchor = i;
        ord[0] = anchor;
        ord[anchor] = 0;
        for (i = 2; i < n; i++) begin
            k = ord[i];
            j = i;
            while (j > 1 && goes_first(anchor, k, ord[j-1])) begin
                ord[j] = ord[j-1];
                j--;
            end
            ord[j] = k;
        end
        // The run of points collinear with the final ray is walked back out.
        if (n >= 3) begin
            for (i = n - 2; i > 0; i--)
                if (cross_sign(anchor, ord[n-1], ord[i]) != 0) begin
                    tail = i;
                    break;
                end
            i = tail + 1;
            j = n - 1;
            while (i < j) begin
                tmp = ord[i]; ord[i] = ord[j]; ord[j] = tmp;
                i++; j--;
            end
        end
        for (i = 0; i < n; i++) begin
            w.idx = ord[i][5:0];
            w.last = (i == n - 1);
            order_queue.push_back(w);
        end
    endtask

    always @(posedge aclk) begin
        order_word_t want;
        if (!aresetn) begin
            set_size <= 0;
            fail_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (order_queue.size() == 0) begin
                    $display("%0t: unexpected word idx=%0d last=%0b", $time,
                             m_tdata[5:0], m_tlast);
                    fail_count <= fail_count + 1;
                end else begin
                    want = order_queue.pop_front();
                    if (m_tdata !== {2'b00, want.idx} || m_tlast !== want.last) begin
                        $display("%0t: expected idx=%0d last=%0b, got idx=%0d last=%0b",
                                 $time, want.idx, want.last, m_tdata, m_tlast);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                int n;
                n = set_size;
                if (n < MAX_POINTS) begin
                    set_x[n] = longint'($signed(s_tdata[COORD_BITS-1:0]));
                    set_y[n] = longint'($signed(s_tdata[2*COORD_BITS-1:COORD_BITS]));
                    n++;
                end
                if (s_tlast) begin
                    queue_polygon_order(n);
                    n = 0;
                end
                set_size <= n;
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives point sets of many shapes and sizes into the polygon order block,
// with random gaps and stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_POINTS = 64;
    localparam int COORD_BITS = 16;
    localparam int WATCHDOG_LIMIT = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // x_coord, y_coord
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // point_index, zero fill
    logic        m_tlast;
    int          fail_count;
    int          pending_count;
    int          idle_cycles;
    bit          hold_off;

    polar_sort_simple_polygon_order_core #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) uut (.*);

    polygon_order_checker #(
        .MAX_POINTS(MAX_POINTS),
        .COORD_BITS(COORD_BITS)
    ) checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Sends one point word and waits for it to be taken. tvalid is only
    // dropped when a gap follows, so words can go back to back.
    task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // A set of n points; spread chooses the coordinate range, and small
    // ranges give many duplicates and collinear runs.
    task automatic send_set(int n, int spread);
        int i;
        logic [15:0] x, y;
        for (i = 0; i < n; i++) begin
            if (spread >= 16) begin
                x = 16'($urandom); y = 16'($urandom);
            end else begin
                x = 16'($urandom_range(0, (1 << spread) - 1) - (1 << (spread - 1)));
                y = 16'($urandom_range(0, (1 << spread) - 1) - (1 << (spread - 1)));
            end
            send_point(x, y, i == n - 1);
        end
    endtask

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (600) @(negedge aclk);
                hold_off = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        hold_off = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;
        // Extremes, duplicates of the anchor, collinear rays, tiny sets.
        send_point(16'h8000, 16'h8000, 1'b1);
        send_point(16'h7fff, 16'h7fff, 1'b0);
        send_point(16'h8000, 16'h7fff, 1'b1);
        send_point(16'h7fff, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h8000, 16'h8000, 1'b0);
        send_point(16'h7fff, 16'h7fff, 1'b0);
        send_point(16'h0000, 16'h0000, 1'b1);
        send_point(16'd0, 16'd0, 1'b0);
        send_point(16'd3, 16'd3, 1'b0);
        send_point(16'd1, 16'd1, 1'b0);
        send_point(16'd2, 16'd0, 1'b0);
        send_point(16'd2, 16'd2, 1'b1);
        send_point(16'd5, 16'd5, 1'b0);
        send_point(16'd5, 16'd5, 1'b0);
        send_point(16'd5, 16'd5, 1'b1);
        // Over capacity: the dropped word still closes the set.
        send_set(MAX_POINTS + 3, 16);
        sent = 16 + MAX_POINTS + 3;
        // Long receiver stall while sets keep arriving.
        hold_off = 1'b1;
        send_set(8, 3);
        send_set(6, 16);
        send_set(5, 2);
        sent += 19;
        // Sender pause until every result has come.
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        @(negedge aclk);
        while (sent < 330) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MAX_POINTS)
                                             : $urandom_range(1, 12);
            send_set(n, ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(1, 4));
            sent += n;
        end
        s_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pspo_pkg.sv
rtl/pspo_front.sv
rtl/pspo_job_queue.sv
rtl/pspo_back.sv
rtl/polar_sort_simple_polygon_order_core.sv
tb/polygon_order_checker.sv
tb/tb.sv
